@@ design/rns_fast_base_conversion_macros.svh @@
// Assertion macros for the RNS fast base conversion block.
// Used by the port-level checker; relies on clk_i and rst_ni in scope.
`ifndef RNS_FAST_BASE_CONVERSION_MACROS_SVH
`define RNS_FAST_BASE_CONVERSION_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define RFBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold outside reset.
`define RFBC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ design/rfbc_pkg.sv @@
// Shared types and codes for the RNS fast base conversion block.
// No dependencies.
`default_nettype none
package rfbc_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_TARGET = 2'd0;
  localparam logic [1:0] REG_PSE    = 2'd1;
  localparam logic [1:0] REG_PSCALE = 2'd2;

  // multiplier b-operand sources
  localparam logic [2:0] B_PS     = 3'd0;
  localparam logic [2:0] B_X      = 3'd1;
  localparam logic [2:0] B_T      = 3'd2;
  localparam logic [2:0] B_HINV   = 3'd3;
  localparam logic [2:0] B_HTGT   = 3'd4;
  localparam logic [2:0] B_ADDEND = 3'd5;
  localparam logic [2:0] B_PSCALE = 3'd6;

  typedef struct packed {
    logic       load_in;
    logic       mul_start;
    logic       a_one;       // a operand is 1 (plain reduction)
    logic [2:0] b_sel;
    logic       m_src_q;     // modulus is source modulus, else target
    logic       mul_dest_ps; // product lands in partial sum, else t
    logic       add_to_ps;
    logic       add_to_t;
    logic       out_load;    // also clears the partial sum
    logic       out_sel_t;
  } cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic mul_done;
    logic last;
    logic pse;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

@@ design/rfbc_datapath.sv @@
// Datapath: config registers, word latch, bit-serial modular multiplier,
// accumulator and output register. Uses rfbc_pkg.
`default_nettype none
module rfbc_datapath #(
  parameter int MODULUS_BITS = 62
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire [MODULUS_BITS-1:0]     residue_i,
  input  wire [MODULUS_BITS-1:0]     source_modulus_i,
  input  wire [MODULUS_BITS-1:0]     hat_inverse_i,
  input  wire [MODULUS_BITS-1:0]     hat_mod_target_i,
  input  wire [MODULUS_BITS-1:0]     addend_i,
  input  wire                        last_i,
  input  wire                        cfg_we_i,
  input  wire [1:0]                  cfg_index_i,
  input  wire [MODULUS_BITS-1:0]     cfg_data_i,
  input  rfbc_pkg::cmd_t             cmd_i,
  output rfbc_pkg::status_t          status_o,
  input  wire                        out_ready_i,
  output logic                       out_valid_o,
  output logic [MODULUS_BITS-1:0]    out_data_o
);
  localparam int W  = MODULUS_BITS;
  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  logic [W-1:0] tgt_q, psc_q;
  logic         pse_q;
  logic [W-1:0] x_q, srcm_q, hinv_q, htgt_q, add_q;
  logic         last_q;
  logic [W-1:0] ps_q, t_q;
  logic         busy_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0] ma_q, mb_q, mm_q, mr_q;
  logic         out_valid_q;
  logic [W-1:0] out_q;

  logic [W:0]   dbl, sum;
  logic [W-1:0] mr_d, mul_res, b_op, m_op, acc;
  logic         mul_done, out_free;

  // one shift-and-add step: r = 2r (+a) mod m
  always_comb begin
    dbl = {mr_q, 1'b0};
    if (dbl >= {1'b0, mm_q}) dbl = dbl - {1'b0, mm_q};
    sum = {1'b0, dbl[W-1:0]} + (mb_q[W-1] ? {1'b0, ma_q} : {(W+1){1'b0}});
    if (sum >= {1'b0, mm_q}) sum = sum - {1'b0, mm_q};
    mr_d = sum[W-1:0];
  end

  assign mul_done = busy_q && (cnt_q == CNT_LAST);
  assign mul_res  = (mm_q < W'(2)) ? '0 : mr_d;
  assign acc      = (tgt_q == '0) ? '0 : add_mod(ps_q, t_q, tgt_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign m_op     = cmd_i.m_src_q ? srcm_q : tgt_q;

  always_comb begin
    case (cmd_i.b_sel)
      rfbc_pkg::B_PS:     b_op = ps_q;
      rfbc_pkg::B_X:      b_op = x_q;
      rfbc_pkg::B_T:      b_op = t_q;
      rfbc_pkg::B_HINV:   b_op = hinv_q;
      rfbc_pkg::B_HTGT:   b_op = htgt_q;
      rfbc_pkg::B_ADDEND: b_op = add_q;
      rfbc_pkg::B_PSCALE: b_op = psc_q;
      default:            b_op = '0;
    endcase
  end

  // config and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q       <= W'(3);
      pse_q       <= 1'b0;
      psc_q       <= W'(1);
      ps_q        <= '0;
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          rfbc_pkg::REG_TARGET: tgt_q <= cfg_data_i;
          rfbc_pkg::REG_PSE:    pse_q <= cfg_data_i[0];
          rfbc_pkg::REG_PSCALE: psc_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.mul_start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (mul_done) busy_q <= 1'b0;
      end
      if (cmd_i.out_load) ps_q <= '0;
      else if (cmd_i.add_to_ps) ps_q <= acc;
      else if (mul_done && cmd_i.mul_dest_ps) ps_q <= mul_res;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q    <= residue_i;
      srcm_q <= source_modulus_i;
      hinv_q <= hat_inverse_i;
      htgt_q <= hat_mod_target_i;
      add_q  <= addend_i;
      last_q <= last_i;
    end
    if (cmd_i.mul_start && !busy_q) begin
      ma_q <= cmd_i.a_one ? W'(1) : t_q;
      mb_q <= b_op;
      mm_q <= m_op;
      mr_q <= '0;
    end else if (busy_q) begin
      mr_q <= mr_d;
      mb_q <= {mb_q[W-2:0], 1'b0};
    end
    if (cmd_i.add_to_t) t_q <= acc;
    else if (mul_done && !cmd_i.mul_dest_ps) t_q <= mul_res;
    if (cmd_i.out_load) out_q <= cmd_i.out_sel_t ? t_q : ps_q;
  end

  assign status_o.mul_busy = busy_q;
  assign status_o.mul_done = mul_done;
  assign status_o.last     = last_q;
  assign status_o.pse      = pse_q;
  assign status_o.out_free = out_free;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
endmodule
`default_nettype wire

@@ design/rfbc_ctrl.sv @@
// Controller: sequences the modular multiplications, accumulate and output.
// Uses rfbc_pkg.
`default_nettype none
module rfbc_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  rfbc_pkg::status_t  status_i,
  output rfbc_pkg::cmd_t     cmd_o
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RPS  = 4'd1;  // ps mod target
  localparam logic [3:0] S_RX   = 4'd2;  // x mod q
  localparam logic [3:0] S_TQ   = 4'd3;  // x*hinv mod q
  localparam logic [3:0] S_RT   = 4'd4;  // t mod target
  localparam logic [3:0] S_PT   = 4'd5;  // t*htgt mod target
  localparam logic [3:0] S_ACC  = 4'd6;
  localparam logic [3:0] S_RA   = 4'd7;  // addend mod target
  localparam logic [3:0] S_AD2  = 4'd8;
  localparam logic [3:0] S_SC   = 4'd9;  // * post_scale
  localparam logic [3:0] S_OUTS = 4'd10;
  localparam logic [3:0] S_OUTT = 4'd11;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    cmd_o.mul_start = !status_i.mul_busy;
    case (state_q)
      S_IDLE: begin
        cmd_o.mul_start = 1'b0;
        cmd_o.load_in   = in_valid_i;
        if (in_valid_i) state_d = S_RPS;
      end
      S_RPS: begin
        cmd_o.a_one = 1'b1; cmd_o.b_sel = rfbc_pkg::B_PS; cmd_o.mul_dest_ps = 1'b1;
        if (status_i.mul_done) state_d = S_RX;
      end
      S_RX: begin
        cmd_o.a_one = 1'b1; cmd_o.b_sel = rfbc_pkg::B_X; cmd_o.m_src_q = 1'b1;
        if (status_i.mul_done) state_d = S_TQ;
      end
      S_TQ: begin
        cmd_o.b_sel = rfbc_pkg::B_HINV; cmd_o.m_src_q = 1'b1;
        if (status_i.mul_done) state_d = S_RT;
      end
      S_RT: begin
        cmd_o.a_one = 1'b1; cmd_o.b_sel = rfbc_pkg::B_T;
        if (status_i.mul_done) state_d = S_PT;
      end
      S_PT: begin
        cmd_o.b_sel = rfbc_pkg::B_HTGT;
        if (status_i.mul_done) state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.mul_start = 1'b0;
        cmd_o.add_to_ps = 1'b1;
        if (!status_i.last) state_d = S_IDLE;
        else if (status_i.pse) state_d = S_RA;
        else state_d = S_OUTS;
      end
      S_RA: begin
        cmd_o.a_one = 1'b1; cmd_o.b_sel = rfbc_pkg::B_ADDEND;
        if (status_i.mul_done) state_d = S_AD2;
      end
      S_AD2: begin
        cmd_o.mul_start = 1'b0;
        cmd_o.add_to_t  = 1'b1;
        state_d = S_SC;
      end
      S_SC: begin
        cmd_o.b_sel = rfbc_pkg::B_PSCALE;
        if (status_i.mul_done) state_d = S_OUTT;
      end
      S_OUTS, S_OUTT: begin
        cmd_o.mul_start = 1'b0;
        cmd_o.out_sel_t = (state_q == S_OUTT);
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        cmd_o.mul_start = 1'b0;
        state_d = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

@@ design/rns_fast_base_conversion.sv @@
// RNS fast base conversion: one word per source residue, result on last.
// Each word runs five modular multiplies on the single bit-serial multiplier,
// then accumulates; a last word with post-scaling then adds the addend mod target
// and multiplies by post_scale before the output register is loaded. One word in
// flight at a time: input is taken only while idle. Reset (rst_ni, async, low)
// clears partial sum and handshakes; config resets to target 3, no post-scale.
`default_nettype none
module rns_fast_base_conversion #(
  parameter int MODULUS_BITS = 62
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  // input words
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire [MODULUS_BITS-1:0]   residue_i,
  input  wire [MODULUS_BITS-1:0]   source_modulus_i,
  input  wire [MODULUS_BITS-1:0]   hat_inverse_i,
  input  wire [MODULUS_BITS-1:0]   hat_mod_target_i,
  input  wire [MODULUS_BITS-1:0]   addend_i,
  input  wire                      last_i,
  // result words
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output logic [MODULUS_BITS-1:0]  converted_residue_o,
  // config write port
  input  wire                      cfg_we_i,
  input  wire [1:0]                cfg_index_i,
  input  wire [MODULUS_BITS-1:0]   cfg_data_i
);
  // Per word the controller steps through: reduce the partial sum mod target,
  // x mod q, t = x*hinv mod q, t mod target, t*htgt mod target, accumulate.
  // Every multiply keeps its a operand below the modulus; b may be unreduced
  // since each shift-and-add step reduces. Reductions run as 1*b mod m.
  rfbc_pkg::cmd_t    cmd;
  rfbc_pkg::status_t status;

  rfbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rfbc_datapath #(.MODULUS_BITS(MODULUS_BITS)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .residue_i        (residue_i),
    .source_modulus_i (source_modulus_i),
    .hat_inverse_i    (hat_inverse_i),
    .hat_mod_target_i (hat_mod_target_i),
    .addend_i         (addend_i),
    .last_i           (last_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .out_data_o       (converted_residue_o)
  );
endmodule
`default_nettype wire

@@ design/rfbc_checker.sv @@
// Port-level checker for rns_fast_base_conversion, bound to the top level.
// Uses rns_fast_base_conversion_macros.svh.
`default_nettype none
`include "rns_fast_base_conversion_macros.svh"
module rfbc_checker #(
  parameter int MODULUS_BITS = 62
) (
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      in_valid_i,
  input wire                      in_ready_o,
  input wire                      out_valid_o,
  input wire                      out_ready_i,
  input wire [MODULUS_BITS-1:0]   converted_residue_o
);
  `RFBC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(converted_residue_o), "result word dropped or changed while stalled")
  `RFBC_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "input taken again while a word is in work")
  `RFBC_ASSERT(a_no_instant_result, in_valid_i && in_ready_o |=> !$rose(out_valid_o), "result appeared too soon after accept")
endmodule

bind rns_fast_base_conversion rfbc_checker #(.MODULUS_BITS(MODULUS_BITS)) u_rfbc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_ready_o          (in_ready_o),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .converted_residue_o (converted_residue_o)
);
`default_nettype wire
